FILE: sv/ntrp_pkg.sv
// Package for the NDEF text record parser: phases, status codes, queue entry types.
// Used by ntrp_front, ntrp_back and the top level.
package ntrp_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam logic [15:0] MaxLenReset = 16'd260;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEAD, PH_LEN, PH_LENHI, PH_LENLO, PH_HDR, PH_TYPELEN, PH_PLEN,
    PH_IDLEN, PH_TYPE, PH_ID, PH_STATUS, PH_LANG, PH_TEXT, PH_SKIP
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_NO_TLV = 4'd1, ST_BAD_TLV = 4'd2, ST_EMPTY = 4'd3, ST_TOO_LONG = 4'd4,
    ST_NOT_WK = 4'd5, ST_NOT_TEXT = 4'd6, ST_CORRUPT = 4'd7, ST_READ_FAIL = 4'd8
  } status_e;

  // What the front hands to the back for one accepted byte.
  typedef enum logic [1:0] {
    OP_PLAIN, OP_UNIT, OP_STATUS
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] unit;       // text byte in [7:0], or UTF-16 code unit
    logic        can_hold;   // another unit follows, so a high surrogate may wait
    logic        flush;      // drop a held surrogate (new text section)
    logic [3:0]  status;
    logic        term_miss;
  } cmd_t;

endpackage

FILE: sv/ndef_text_record_parser_unit.sv
// NDEF text record parser top level: configuration port, front and back parts.
// Depends on ntrp_pkg, ntrp_front, ntrp_back.
// Takes one tag byte per cycle while the four-entry command queue has room; a byte that
// yields a result is queued as a command, and the back sends its results one per cycle
// while out_ready_i is high (a text byte, up to four UTF-8 bytes for a UTF-16 unit or
// surrogate pair, up to six when a held lone surrogate goes out ahead of the next unit,
// or one status item). Sustained rate is set by the back's output port and out_ready_i.
module ndef_text_record_parser_unit #(
  parameter logic [15:0] MaxLenDefault = ntrp_pkg::MaxLenReset
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  tag_byte_i,
  input  logic        start_req_i,
  input  logic        read_fail_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  text_byte_o,
  output logic [3:0]  status_o,
  output logic        terminator_missing_o,
  output logic        last_o
);

  logic [15:0]    max_len_q;
  logic           cmd_valid, cmd_ready;
  ntrp_pkg::cmd_t cmd;
  logic           fbusy, bbusy;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {16'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) max_len_q <= MaxLenDefault;
    else if (psel && penable && pwrite && paddr == 2'd0) max_len_q <= pwdata[15:0];
  end

  ntrp_front u_front (
    .clk_i, .rst_ni, .max_len_i(max_len_q), .in_valid_i, .in_ready_o,
    .tag_byte_i, .start_req_i, .read_fail_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_ready_i(cmd_ready), .busy_o(fbusy)
  );

  ntrp_back u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_ready_o(cmd_ready),
    .out_valid_o, .out_ready_i, .kind_o, .text_byte_o, .status_o,
    .terminator_missing_o, .last_o, .busy_o(bbusy)
  );

  a_tm_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && terminator_missing_o |-> kind_o && status_o == 4'd0)
    else $error("terminator flag on non-ok status");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> last_o)
    else $error("status item not last");
  a_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid |-> fbusy)
    else $error("queue valid while empty");
  a_back_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bbusy && !out_ready_i |=> bbusy)
    else $error("back dropped a result");

endmodule

FILE: sv/ntrp_front.sv
// Front part: accepts tag bytes, walks the TLV and record header, classifies each byte.
// Depends on ntrp_pkg; feeds ntrp_back through a command queue.
module ntrp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [15:0]         max_len_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          tag_byte_i,
  input  logic                start_req_i,
  input  logic                read_fail_i,
  output logic                cmd_valid_o,
  output ntrp_pkg::cmd_t      cmd_o,
  input  logic                cmd_ready_i,
  output logic                busy_o
);

  localparam int unsigned QW = $clog2(ntrp_pkg::QueueDepth);

  ntrp_pkg::phase_e phase_q, phase_d;
  logic [16:0] pos_q, pos_d;
  logic [1:0]  zc_q, zc_d;
  logic [15:0] mlen_q, mlen_d;
  logic [16:0] tot_q, tot_d;
  logic [1:0]  flags_q, flags_d;
  logic [31:0] plen_q, plen_d;
  logic [7:0]  cnt_q, cnt_d;
  logic        u16_q, u16_d;
  logic [32:0] rem_q, rem_d;
  logic [7:0]  hi_q, hi_d;
  logic        fresh_q, fresh_d;

  ntrp_pkg::cmd_t mem_q [ntrp_pkg::QueueDepth];
  logic [QW-1:0]  wp_q, rp_q;
  logic [QW:0]    fill_q;

  logic           emit;
  ntrp_pkg::cmd_t cmd;
  logic           accept;
  logic [16:0]    pos;
  logic [7:0]     b;
  logic [17:0]    tot_calc;
  logic [5:0]     lang;
  logic [32:0]    rem_next;
  logic [32:0]    end_pos;

  assign in_ready_o  = (fill_q != (QW+1)'(ntrp_pkg::QueueDepth));
  assign accept      = in_valid_i && in_ready_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = mem_q[rp_q];
  assign busy_o      = cmd_valid_o;
  assign b           = tag_byte_i;
  assign lang        = b[5:0];
  assign rem_next    = rem_q - 33'd1;
  assign end_pos     = 33'(pos) + 33'(plen_q);

  always_comb begin
    phase_d = phase_q; pos_d = pos_q; zc_d = zc_q; mlen_d = mlen_q; tot_d = tot_q;
    flags_d = flags_q; plen_d = plen_q; cnt_d = cnt_q; u16_d = u16_q; rem_d = rem_q;
    hi_d = hi_q; fresh_d = fresh_q;
    emit = 1'b0;
    cmd  = '{op: ntrp_pkg::OP_PLAIN, unit: 16'd0, can_hold: 1'b0, flush: 1'b0,
             status: 4'd0, term_miss: 1'b0};
    tot_calc = '0;
    pos = pos_q;
    if (start_req_i) begin
      phase_d = ntrp_pkg::PH_LEAD; pos = '0; zc_d = '0; mlen_d = '0; tot_d = '0;
      flags_d = '0; plen_d = '0; cnt_d = '0; u16_d = 1'b0; rem_d = '0; hi_d = '0;
      fresh_d = 1'b0;
    end
    if (start_req_i || phase_q != ntrp_pkg::PH_IDLE) begin
      if (read_fail_i) begin
        emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_READ_FAIL;
        phase_d = ntrp_pkg::PH_IDLE;
      end else begin
        pos_d = pos + 17'd1;
        if (phase_d >= ntrp_pkg::PH_HDR && (pos + 17'd1) == tot_d) begin
          emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS;
          if (phase_d == ntrp_pkg::PH_SKIP) begin
            cmd.status = ntrp_pkg::ST_OK; cmd.term_miss = (b != 8'hFE);
          end else begin
            cmd.status = ntrp_pkg::ST_CORRUPT;
          end
          phase_d = ntrp_pkg::PH_IDLE;
        end else begin
          case (phase_d)
            ntrp_pkg::PH_LEAD: begin
              if (b == 8'h00 && zc_d < 2'd2) zc_d = zc_d + 2'd1;
              else if (b == 8'h03) phase_d = ntrp_pkg::PH_LEN;
              else begin
                emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_NO_TLV;
                phase_d = ntrp_pkg::PH_IDLE;
              end
            end
            ntrp_pkg::PH_LEN, ntrp_pkg::PH_LENLO: begin
              if (phase_d == ntrp_pkg::PH_LEN && b == 8'hFF) begin
                if (zc_d != 2'd0) begin
                  emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_BAD_TLV;
                  phase_d = ntrp_pkg::PH_IDLE;
                end else phase_d = ntrp_pkg::PH_LENHI;
              end else begin
                if (phase_d == ntrp_pkg::PH_LEN) mlen_d = {8'd0, b};
                else mlen_d = {mlen_d[15:8], b};
                tot_calc = 18'(zc_d) + ((phase_d == ntrp_pkg::PH_LENLO) ? 18'd4 : 18'd2)
                           + 18'(mlen_d) + 18'd1;
                tot_d = tot_calc[16:0];
                if (mlen_d == 16'd0) begin
                  emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_EMPTY;
                  phase_d = ntrp_pkg::PH_IDLE;
                end else if (tot_calc > 18'(max_len_i)) begin
                  emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_TOO_LONG;
                  phase_d = ntrp_pkg::PH_IDLE;
                end else phase_d = ntrp_pkg::PH_HDR;
              end
            end
            ntrp_pkg::PH_LENHI: begin
              mlen_d = {b, 8'd0}; phase_d = ntrp_pkg::PH_LENLO;
            end
            ntrp_pkg::PH_HDR: begin
              if (b[2:0] != 3'd1) begin
                emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_NOT_WK;
                phase_d = ntrp_pkg::PH_IDLE;
              end else begin
                flags_d = {b[4], b[3]}; phase_d = ntrp_pkg::PH_TYPELEN;
              end
            end
            ntrp_pkg::PH_TYPELEN: begin
              if (b != 8'd1) begin
                emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_NOT_TEXT;
                phase_d = ntrp_pkg::PH_IDLE;
              end else begin
                plen_d = '0; cnt_d = flags_d[1] ? 8'd1 : 8'd4; phase_d = ntrp_pkg::PH_PLEN;
              end
            end
            ntrp_pkg::PH_PLEN: begin
              plen_d = {plen_d[23:0], b};
              if (cnt_d != 8'd0) cnt_d = cnt_d - 8'd1;
              if (cnt_d == 8'd0)
                phase_d = flags_d[0] ? ntrp_pkg::PH_IDLEN : ntrp_pkg::PH_TYPE;
            end
            ntrp_pkg::PH_IDLEN: begin
              cnt_d = b; phase_d = ntrp_pkg::PH_TYPE;
            end
            ntrp_pkg::PH_TYPE: begin
              if (b != 8'h54) begin
                emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_NOT_TEXT;
                phase_d = ntrp_pkg::PH_IDLE;
              end else phase_d = (cnt_d != 8'd0) ? ntrp_pkg::PH_ID : ntrp_pkg::PH_STATUS;
            end
            ntrp_pkg::PH_ID: begin
              if (cnt_d != 8'd0) cnt_d = cnt_d - 8'd1;
              if (cnt_d == 8'd0) phase_d = ntrp_pkg::PH_STATUS;
            end
            ntrp_pkg::PH_STATUS: begin
              if (33'(plen_d) < 33'd1 + 33'(lang) || end_pos > 33'(tot_d) - 33'd1) begin
                emit = 1'b1; cmd.op = ntrp_pkg::OP_STATUS; cmd.status = ntrp_pkg::ST_CORRUPT;
                phase_d = ntrp_pkg::PH_IDLE;
              end else begin
                u16_d = b[7];
                rem_d = 33'(plen_d) - 33'd1 - 33'(lang);
                fresh_d = 1'b1;
                cnt_d = 8'(lang);
                if (lang == 6'd0)
                  phase_d = (rem_d != '0) ? ntrp_pkg::PH_TEXT : ntrp_pkg::PH_SKIP;
                else phase_d = ntrp_pkg::PH_LANG;
              end
            end
            ntrp_pkg::PH_LANG: begin
              if (cnt_d != 8'd0) cnt_d = cnt_d - 8'd1;
              if (cnt_d == 8'd0)
                phase_d = (rem_d != '0) ? ntrp_pkg::PH_TEXT : ntrp_pkg::PH_SKIP;
            end
            ntrp_pkg::PH_TEXT: begin
              if (rem_d != '0) rem_d = rem_next;
              if (!u16_d) begin
                emit = 1'b1; cmd.unit = {8'd0, b};
              end else if (cnt_d == 8'd0) begin
                hi_d = b; cnt_d = 8'd1;
              end else begin
                cnt_d = 8'd0;
                emit = 1'b1; cmd.op = ntrp_pkg::OP_UNIT; cmd.unit = {hi_d, b};
                cmd.can_hold = (rem_d >= 33'd2); cmd.flush = fresh_d; fresh_d = 1'b0;
              end
              if (rem_d == '0) phase_d = ntrp_pkg::PH_SKIP;
            end
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ntrp_pkg::PH_IDLE; pos_q <= '0; zc_q <= '0; mlen_q <= '0; tot_q <= '0;
      flags_q <= '0; plen_q <= '0; cnt_q <= '0; u16_q <= 1'b0; rem_q <= '0; hi_q <= '0;
      fresh_q <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d; pos_q <= pos_d; zc_q <= zc_d; mlen_q <= mlen_d; tot_q <= tot_d;
      flags_q <= flags_d; plen_q <= plen_d; cnt_q <= cnt_d; u16_q <= u16_d; rem_q <= rem_d;
      hi_q <= hi_d; fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) mem_q[wp_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; fill_q <= '0;
    end else begin
      if (accept && emit) wp_q <= wp_q + QW'(1);
      if (cmd_valid_o && cmd_ready_i) rp_q <= rp_q + QW'(1);
      fill_q <= fill_q + (QW+1)'(accept && emit) - (QW+1)'(cmd_valid_o && cmd_ready_i);
    end
  end

endmodule

FILE: sv/ntrp_back.sv
// Back part: pairs surrogates, encodes UTF-8, and sends result items one per cycle while out_ready_i is high.
// Depends on ntrp_pkg; takes commands from ntrp_front.
module ntrp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  input  ntrp_pkg::cmd_t cmd_i,
  output logic           cmd_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           kind_o,
  output logic [7:0]     text_byte_o,
  output logic [3:0]     status_o,
  output logic           terminator_missing_o,
  output logic           last_o,
  output logic           busy_o
);

  // Up to two code points per command (held surrogate, then current), each up to 4 bytes.
  logic [7:0]  buf_q [7];
  logic [2:0]  cnt_q, idx_q;
  logic        isst_q;
  logic [3:0]  st_q;
  logic        tm_q;
  logic        act_q;
  logic [15:0] hs_q;
  logic        hv_q;

  logic [7:0]  nb [7];
  logic [2:0]  nn;
  logic [15:0] hs_d;
  logic        hv_d;
  logic        take;
  logic        done;
  logic [20:0] cpa, cpb;
  logic        ena, enb;
  logic [7:0]  ea [4];
  logic [7:0]  eb [4];
  logic [2:0]  la, lb;
  logic        hv_in;
  logic        is_lo, is_hi;

  function automatic logic [2:0] enc_len(input logic [20:0] cp);
    if (cp < 21'h80) return 3'd1;
    else if (cp < 21'h800) return 3'd2;
    else if (cp < 21'h10000) return 3'd3;
    else return 3'd4;
  endfunction

  function automatic logic [31:0] enc(input logic [20:0] cp);
    if (cp < 21'h80) return {cp[7:0], 24'd0};
    else if (cp < 21'h800) return {3'b110, cp[10:6], 2'b10, cp[5:0], 16'd0};
    else if (cp < 21'h10000)
      return {4'b1110, cp[15:12], 2'b10, cp[11:6], 2'b10, cp[5:0], 8'd0};
    else return {5'b11110, cp[20:18], 2'b10, cp[17:12], 2'b10, cp[11:6], 2'b10, cp[5:0]};
  endfunction

  assign done        = act_q && out_ready_i && (idx_q + 3'd1 == cnt_q);
  assign cmd_ready_o = !act_q || done;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = act_q;
  assign kind_o      = isst_q;
  assign text_byte_o = isst_q ? 8'd0 : buf_q[idx_q];
  assign status_o    = isst_q ? st_q : 4'd0;
  assign terminator_missing_o = isst_q && tm_q;
  assign last_o      = (idx_q + 3'd1 == cnt_q);
  assign busy_o      = act_q;

  always_comb begin
    hv_in = hv_q && !cmd_i.flush;
    is_lo = (cmd_i.unit >= 16'hDC00) && (cmd_i.unit <= 16'hDFFF);
    is_hi = (cmd_i.unit >= 16'hD800) && (cmd_i.unit <= 16'hDBFF);
    hs_d = hs_q; hv_d = hv_in;
    ena = 1'b0; enb = 1'b0;
    cpa = 21'(hs_q); cpb = 21'(cmd_i.unit);
    if (cmd_i.op == ntrp_pkg::OP_UNIT) begin
      hv_d = 1'b0;
      if (hv_in && is_lo) begin
        ena = 1'b1;
        cpa = 21'h10000 + {1'b0, hs_q[9:0], 10'd0} + 21'(cmd_i.unit[9:0]);
      end else begin
        ena = hv_in;
        if (is_hi && cmd_i.can_hold) begin
          hs_d = cmd_i.unit; hv_d = 1'b1;
        end else enb = 1'b1;
      end
    end
    la = ena ? enc_len(cpa) : 3'd0;
    lb = enb ? enc_len(cpb) : 3'd0;
    {ea[0], ea[1], ea[2], ea[3]} = enc(cpa);
    {eb[0], eb[1], eb[2], eb[3]} = enc(cpb);
    for (int i = 0; i < 7; i++) nb[i] = 8'd0;
    for (int i = 0; i < 4; i++) if (3'(i) < la) nb[i] = ea[i];
    for (int i = 0; i < 4; i++) if (3'(i) < lb) nb[3'(i) + la] = eb[i];
    nn = (cmd_i.op == ntrp_pkg::OP_PLAIN) ? 3'd1 : la + lb;
    if (cmd_i.op == ntrp_pkg::OP_PLAIN) nb[0] = cmd_i.unit[7:0];
    if (cmd_i.op == ntrp_pkg::OP_STATUS) nn = 3'd1;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int i = 0; i < 7; i++) buf_q[i] <= nb[i];
      st_q <= cmd_i.status; tm_q <= cmd_i.term_miss; hs_q <= hs_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; idx_q <= '0; cnt_q <= '0; isst_q <= 1'b0; hv_q <= 1'b0;
    end else if (take) begin
      act_q <= (nn != 3'd0); idx_q <= '0; cnt_q <= nn;
      isst_q <= (cmd_i.op == ntrp_pkg::OP_STATUS);
      hv_q <= (cmd_i.op == ntrp_pkg::OP_STATUS) ? 1'b0 : hv_d;
    end else if (done) begin
      act_q <= 1'b0;
    end else if (act_q && out_ready_i) begin
      idx_q <= idx_q + 3'd1;
    end
  end

endmodule

FILE: tb/sv/ndef_text_record_parser_unit_tb.sv
// Testbench for ndef_text_record_parser_unit: streams NDEF tag memory into the parser and
// checks each UTF-8 text byte and final status against a built-in parser model.
// Depends on ntrp_pkg and the ndef_text_record_parser_unit RTL.
module ndef_text_record_parser_unit_tb;

  typedef struct {
    bit         kind;
    logic [7:0] text_byte;
    logic [3:0] status;
    bit         term_miss;
    bit         last;
  } parse_result_t;

  class text_record_board;
    parse_result_t pending_results[$];
    parse_result_t step_out[$];
    int            mismatches;
    logic [15:0]   max_len;
    ntrp_pkg::phase_e ph;
    logic [16:0]   byte_pos;
    logic [1:0]    zeros;
    logic [15:0]   msg_len;
    logic [16:0]   total_len;
    logic [1:0]    flags;
    logic [7:0]    type_len;
    logic [31:0]   pay_len;
    logic [7:0]    countdown;
    bit            utf16;
    logic [32:0]   text_left;
    logic [7:0]    high_byte;
    logic [15:0]   surrogate;
    bit            surrogate_held;

    function new();
      max_len = ntrp_pkg::MaxLenReset;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      ph = ntrp_pkg::PH_IDLE; byte_pos = '0; zeros = '0; msg_len = '0; total_len = '0;
      flags = '0; type_len = '0; pay_len = '0; countdown = '0; utf16 = 0;
      text_left = '0; high_byte = '0; surrogate = '0; surrogate_held = 0;
    endfunction

    function void put_text(logic [7:0] b);
      parse_result_t r;
      r.kind = 0; r.text_byte = b; r.status = ntrp_pkg::ST_OK; r.term_miss = 0; r.last = 0;
      step_out.push_back(r);
    endfunction

    function void put_status(ntrp_pkg::status_e st, bit tm);
      parse_result_t r;
      r.kind = 1; r.text_byte = '0; r.status = st; r.term_miss = tm; r.last = 0;
      step_out.push_back(r);
      ph = ntrp_pkg::PH_IDLE;
    endfunction

    function void put_code_point(int unsigned cp);
      if (cp < 'h80) begin
        put_text(8'(cp));
      end else if (cp < 'h800) begin
        put_text(8'('hC0 | (cp >> 6)));
        put_text(8'('h80 | (cp & 'h3F)));
      end else if (cp < 'h10000) begin
        put_text(8'('hE0 | (cp >> 12)));
        put_text(8'('h80 | ((cp >> 6) & 'h3F)));
        put_text(8'('h80 | (cp & 'h3F)));
      end else begin
        put_text(8'('hF0 | (cp >> 18)));
        put_text(8'('h80 | ((cp >> 12) & 'h3F)));
        put_text(8'('h80 | ((cp >> 6) & 'h3F)));
        put_text(8'('h80 | (cp & 'h3F)));
      end
    endfunction

    function void code_unit(logic [15:0] cu);
      int unsigned hs;
      int unsigned ls;
      if (surrogate_held) begin
        surrogate_held = 0;
        if (cu >= 16'hDC00 && cu <= 16'hDFFF) begin
          hs = surrogate;
          ls = cu;
          put_code_point('h10000 + ((hs - 'hD800) << 10) + (ls - 'hDC00));
          return;
        end
        put_code_point(surrogate);
      end
      if (cu >= 16'hD800 && cu <= 16'hDBFF && text_left >= 2) begin
        surrogate = cu;
        surrogate_held = 1;
        return;
      end
      put_code_point(cu);
    endfunction

    function void after_lang();
      countdown = '0;
      ph = (text_left != 0) ? ntrp_pkg::PH_TEXT : ntrp_pkg::PH_SKIP;
    endfunction

    function void parse(logic [7:0] b);
      int unsigned pos;
      int unsigned lang;
      bit          known;
      pos = byte_pos;
      byte_pos = byte_pos + 17'd1;
      known = 0;
      if (ph >= ntrp_pkg::PH_HDR && pos + 1 == int'(total_len)) begin
        if (ph == ntrp_pkg::PH_SKIP) put_status(ntrp_pkg::ST_OK, b != 8'hFE);
        else put_status(ntrp_pkg::ST_CORRUPT, 0);
        return;
      end
      case (ph)
        ntrp_pkg::PH_LEAD: begin
          if (b == 8'h00 && zeros < 2) zeros = zeros + 2'd1;
          else if (b == 8'h03) ph = ntrp_pkg::PH_LEN;
          else put_status(ntrp_pkg::ST_NO_TLV, 0);
        end
        ntrp_pkg::PH_LEN: begin
          if (b == 8'hFF) begin
            if (zeros != 0) put_status(ntrp_pkg::ST_BAD_TLV, 0);
            else ph = ntrp_pkg::PH_LENHI;
          end else begin
            msg_len = {8'h00, b};
            known = 1;
          end
        end
        ntrp_pkg::PH_LENHI: begin
          msg_len = {b, 8'h00};
          ph = ntrp_pkg::PH_LENLO;
        end
        ntrp_pkg::PH_LENLO: begin
          msg_len[7:0] = b;
          known = 1;
        end
        ntrp_pkg::PH_HDR: begin
          if (b[2:0] != 3'd1) begin
            put_status(ntrp_pkg::ST_NOT_WK, 0);
          end else begin
            flags = {b[4], b[3]};
            ph = ntrp_pkg::PH_TYPELEN;
          end
        end
        ntrp_pkg::PH_TYPELEN: begin
          type_len = b;
          if (b != 8'd1) begin
            put_status(ntrp_pkg::ST_NOT_TEXT, 0);
          end else begin
            pay_len = '0;
            countdown = flags[1] ? 8'd1 : 8'd4;
            ph = ntrp_pkg::PH_PLEN;
          end
        end
        ntrp_pkg::PH_PLEN: begin
          pay_len = {pay_len[23:0], b};
          if (countdown != 0) countdown = countdown - 8'd1;
          if (countdown == 0) begin
            ph = flags[0] ? ntrp_pkg::PH_IDLEN : ntrp_pkg::PH_TYPE;
            countdown = '0;
          end
        end
        ntrp_pkg::PH_IDLEN: begin
          countdown = b;
          ph = ntrp_pkg::PH_TYPE;
        end
        ntrp_pkg::PH_TYPE: begin
          if (b != 8'h54) put_status(ntrp_pkg::ST_NOT_TEXT, 0);
          else ph = (countdown != 0) ? ntrp_pkg::PH_ID : ntrp_pkg::PH_STATUS;
        end
        ntrp_pkg::PH_ID: begin
          if (countdown != 0) countdown = countdown - 8'd1;
          if (countdown == 0) ph = ntrp_pkg::PH_STATUS;
        end
        ntrp_pkg::PH_STATUS: begin
          lang = b & 8'h3F;
          if (longint'(pay_len) < 1 + longint'(lang) ||
              longint'(pos) + longint'(pay_len) > longint'(total_len) - 1) begin
            put_status(ntrp_pkg::ST_CORRUPT, 0);
          end else begin
            utf16 = b[7];
            text_left = 33'(pay_len) - 33'd1 - 33'(lang);
            surrogate_held = 0;
            if (lang != 0) begin
              countdown = 8'(lang);
              ph = ntrp_pkg::PH_LANG;
            end else begin
              after_lang();
            end
          end
        end
        ntrp_pkg::PH_LANG: begin
          if (countdown != 0) countdown = countdown - 8'd1;
          if (countdown == 0) after_lang();
        end
        ntrp_pkg::PH_TEXT: begin
          if (text_left != 0) text_left = text_left - 33'd1;
          if (!utf16) begin
            put_text(b);
          end else if (countdown == 0) begin
            high_byte = b;
            countdown = 8'd1;
          end else begin
            countdown = '0;
            code_unit({high_byte, b});
          end
          if (text_left == 0) ph = ntrp_pkg::PH_SKIP;
        end
        default: ;
      endcase
      if (known) begin
        if (msg_len == 0) begin
          put_status(ntrp_pkg::ST_EMPTY, 0);
        end else begin
          total_len = 17'(zeros) + ((ph == ntrp_pkg::PH_LENLO) ? 17'd4 : 17'd2)
                      + 17'(msg_len) + 17'd1;
          if (total_len > 17'(max_len)) put_status(ntrp_pkg::ST_TOO_LONG, 0);
          else ph = ntrp_pkg::PH_HDR;
        end
      end
    endfunction

    function void note_byte(logic [7:0] b, bit start, bit fail);
      step_out.delete();
      if (start) begin
        clear();
        ph = ntrp_pkg::PH_LEAD;
      end else if (ph == ntrp_pkg::PH_IDLE) begin
        return;
      end
      if (fail) put_status(ntrp_pkg::ST_READ_FAIL, 0);
      else parse(b);
      if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1;
      foreach (step_out[i]) pending_results.push_back(step_out[i]);
    endfunction

    function void check_result(bit kind, logic [7:0] tb, logic [3:0] st, bit tm, bit last);
      parse_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind=%0d byte=%h status=%0d term=%0d last=%0d",
                   kind, tb, st, tm, last);
        return;
      end
      e = pending_results.pop_front();
      if (e.kind !== kind || e.text_byte !== tb || e.status !== st ||
          e.term_miss !== tm || e.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected kind=%0d byte=%h status=%0d term=%0d last=%0d,",
                    " got kind=%0d byte=%h status=%0d term=%0d last=%0d"},
                   e.kind, e.text_byte, e.status, e.term_miss, e.last,
                   kind, tb, st, tm, last);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [7:0]  tag_byte_i = '0;
  logic        start_req_i = 0;
  logic        read_fail_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic        kind_o;
  logic [7:0]  text_byte_o;
  logic [3:0]  status_o;
  logic        terminator_missing_o;
  logic        last_o;

  text_record_board board = new();
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          bytes_sent = 0;

  ndef_text_record_parser_unit dut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_result(kind_o, text_byte_o, status_o, terminator_missing_o, last_o);
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic bit sender_idles();
    return $urandom_range(99) < send_idle_pct;
  endfunction

  // Send one request stream; start on the first byte when asked, read failure at fail_at.
  task automatic send_stream(input logic [7:0] data[$], input bit with_start, input int fail_at);
    @(posedge clk_i);
    while (sender_idles()) @(posedge clk_i);
    for (int i = 0; i < data.size(); i++) begin
      if (i > 0 && sender_idles()) begin
        in_valid_i <= 0;
        @(posedge clk_i);
        while (sender_idles()) @(posedge clk_i);
      end
      in_valid_i  <= 1;
      tag_byte_i  <= data[i];
      start_req_i <= with_start && i == 0;
      read_fail_i <= i == fail_at;
      do @(posedge clk_i); while (!in_ready_o);
      board.note_byte(data[i], with_start && i == 0, i == fail_at);
      bytes_sent++;
    end
    in_valid_i <= 0;
  endtask

  task automatic wait_drained();
    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    wait_drained();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= 2'd0; pwdata <= {16'h0, value};
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    board.max_len = value;
  endtask

  task automatic build_message(output logic [7:0] m[$]);
    logic [7:0] rec[$];
    logic [7:0] pay[$];
    logic [15:0] cu[$];
    int  z, lang, id_len, plen, mlen;
    bit  sr, il, u16, long_len;
    z = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
    long_len = z == 0 && $urandom_range(3) == 0;
    sr = $urandom_range(4) != 0;
    il = $urandom_range(2) == 0;
    u16 = $urandom_range(1);
    lang = $urandom_range(0, 5);
    m = {};
    pay.push_back({u16, 1'($urandom), 6'(lang)});
    repeat (lang) pay.push_back(8'($urandom_range(8'h61, 8'h7A)));
    if (!u16) begin
      repeat ($urandom_range(0, 10)) pay.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(5))
          0: cu.push_back(16'($urandom_range('h00, 'h7F)));
          1: cu.push_back(16'($urandom_range('h80, 'h7FF)));
          2: cu.push_back(16'($urandom_range('h800, 'hFFFF)));
          3: begin
            cu.push_back(16'('hD800 + $urandom_range('h3FF)));
            cu.push_back(16'('hDC00 + $urandom_range('h3FF)));
          end
          4: cu.push_back(16'('hD800 + $urandom_range('h3FF)));
          default: cu.push_back(16'('hDC00 + $urandom_range('h3FF)));
        endcase
      end
      foreach (cu[i]) begin
        pay.push_back(cu[i][15:8]);
        pay.push_back(cu[i][7:0]);
      end
      if ($urandom_range(3) == 0) pay.push_back(8'($urandom));
    end
    plen = pay.size();
    rec.push_back(8'(($urandom & 'hE0) | (sr ? 'h10 : 0) | (il ? 'h08 : 0) | 'h01));
    rec.push_back(8'd1);
    if (sr) begin
      rec.push_back(8'(plen));
    end else begin
      rec.push_back(8'h00); rec.push_back(8'h00); rec.push_back(8'h00);
      rec.push_back(8'(plen));
    end
    id_len = $urandom_range(0, 3);
    if (il) rec.push_back(8'(id_len));
    rec.push_back(8'h54);
    if (il) repeat (id_len) rec.push_back(8'($urandom));
    foreach (pay[i]) rec.push_back(pay[i]);
    repeat ($urandom_range(0, 2)) rec.push_back(8'($urandom));
    mlen = rec.size();
    repeat (z) m.push_back(8'h00);
    m.push_back(8'h03);
    if (long_len) begin
      m.push_back(8'hFF);
      m.push_back(8'(mlen >> 8));
      m.push_back(8'(mlen));
    end else begin
      m.push_back(8'(mlen));
    end
    foreach (rec[i]) m.push_back(rec[i]);
    m.push_back(($urandom_range(4) == 0) ? 8'($urandom) : 8'hFE);
    if ($urandom_range(5) == 0) m[$urandom_range(m.size() - 1)] = 8'($urandom);
    if ($urandom_range(9) == 0) m = m[0:$urandom_range(m.size() - 1)];
  endtask

  task automatic random_messages(input int target);
    logic [7:0] m[$];
    logic [7:0] noise[$];
    int         goal;
    goal = bytes_sent + target;
    while (bytes_sent < goal) begin
      if ($urandom_range(7) == 0) begin
        noise = {};
        repeat ($urandom_range(1, 3)) noise.push_back(8'($urandom));
        send_stream(noise, 0, $urandom_range(1) ? 0 : -1);
      end
      build_message(m);
      send_stream(m, 1, ($urandom_range(9) == 0) ? $urandom_range(m.size() - 1) : -1);
    end
  endtask

  initial begin
    logic [15:0] settings[4];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    send_stream('{8'h03, 8'h05, 8'hD1, 8'h01, 8'h01, 8'h54, 8'h00, 8'hFE}, 1, -1);
    send_stream('{8'h05}, 1, -1);
    send_stream('{8'h00, 8'h03, 8'hFF}, 1, -1);
    send_stream('{8'h03, 8'h00}, 1, -1);
    send_stream('{8'h03, 8'hFE}, 1, -1);
    send_stream('{8'h03, 8'h04, 8'h12}, 1, -1);
    send_stream('{8'h03, 8'h04, 8'hD1, 8'h02}, 1, -1);
    send_stream('{8'h00, 8'h03}, 1, 1);
    send_stream('{8'hFF}, 0, 0);

    settings = '{16'hFFFF, 16'd8, 16'($urandom_range(8, 300)), 16'd260};
    for (int k = 0; k < 4; k++) begin
      write_max_len(settings[k]);
      case (k)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      random_messages(12);
      wait_drained();
      random_messages(12);
    end

    wait_drained();
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("ndef_text_record_parser_unit verification clean");
    end else begin
      $display("ndef_text_record_parser_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("ndef_text_record_parser_unit verification failed");
    $finish;
  end

endmodule

FILE: files.f
sv/ntrp_pkg.sv
sv/ntrp_front.sv
sv/ntrp_back.sv
sv/ndef_text_record_parser_unit.sv
tb/sv/ndef_text_record_parser_unit_tb.sv
